FILE: src/masked_pair_distance_extremes_macros.svh
// Assertion macros for the masked pair distance extremes block.
// Taken in by the modules that assert; no other dependencies.
`ifndef MASKED_PAIR_DISTANCE_EXTREMES_MACROS_SVH
`define MASKED_PAIR_DISTANCE_EXTREMES_MACROS_SVH

`ifndef ASSERT_OFF
`define MPDE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MPDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MPDE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define MPDE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: src/mpde_pkg.sv
// Shared types and constants of the masked pair distance extremes block.
// No dependencies; used by every module of the block but mpde_queue.
`timescale 1ns / 1ps

package mpde_pkg;

   localparam int MAX_POINTS_DEFAULT = 64;
   localparam int DIST_WIDTH_DEFAULT = 32;

   localparam int INDEX_PORT_W = 6;
   localparam int DIST_PORT_W  = 32;
   localparam int COUNT_PORT_W = 7;

   localparam logic [COUNT_PORT_W-1:0] POINT_COUNT_RESET = 7'd64;

   // widest fields over the parameter range
   localparam int MAX_IDX_W  = 10;
   localparam int MAX_ADDR_W = 19;
   localparam int MAX_DIST_W = 64;

   localparam int CMD_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_MASK = 2'd1,
      OP_EVAL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic [MAX_ADDR_W-1:0]   addr;
      logic [MAX_DIST_W-1:0]   distance;
      logic [MAX_IDX_W-1:0]    point;
      logic                    on;
   } cmd_type;

   typedef struct packed {
      logic                    delta_found;
      logic [DIST_PORT_W-1:0]  delta_value;
      logic [INDEX_PORT_W-1:0] delta_first;
      logic [INDEX_PORT_W-1:0] delta_second;
      logic                    epsilon_found;
      logic [DIST_PORT_W-1:0]  epsilon_value;
      logic [INDEX_PORT_W-1:0] epsilon_first;
      logic [INDEX_PORT_W-1:0] epsilon_second;
      logic [COUNT_PORT_W-1:0] active_count;
   } res_type;

endpackage

FILE: src/mpde_queue.sv
// Small register queue with push/full and pop/empty sides.
// No dependencies; carries commands and results of the block.
`timescale 1ns / 1ps

module mpde_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rdata   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CW'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: src/mpde_front.sv
// Request front end: accepts, filters and classifies requests.
// Depends on mpde_pkg; feeds the command queue.
`timescale 1ns / 1ps

module mpde_front #(
   parameter int MAX_POINTS = mpde_pkg::MAX_POINTS_DEFAULT,
   parameter int DIST_WIDTH = mpde_pkg::DIST_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [1:0]                          req_command,
   input  logic [mpde_pkg::INDEX_PORT_W-1:0]   req_row_index,
   input  logic [mpde_pkg::INDEX_PORT_W-1:0]   req_col_index,
   input  logic [mpde_pkg::DIST_PORT_W-1:0]    req_distance_value,
   input  logic                                req_mask_on,
   output logic                                cq_push,
   input  logic                                cq_full,
   output mpde_pkg::cmd_type                   cq_data
);

   localparam int PW = 2 * mpde_pkg::INDEX_PORT_W;

   logic                                 stage_valid_ff, stage_valid_in;
   mpde_pkg::cmd_type                    stage_cmd_ff, stage_cmd_in;
   logic                                 accept, keep;
   logic                                 row_ok, col_ok;
   logic [mpde_pkg::INDEX_PORT_W-1:0]    hi, lo;
   logic [PW-1:0]                        prod;

   assign req_full = stage_valid_ff && cq_full;
   assign accept   = req_push && !req_full;
   assign cq_push  = stage_valid_ff;
   assign cq_data  = stage_cmd_ff;

   assign row_ok = (32'(req_row_index) < 32'(MAX_POINTS));
   assign col_ok = (32'(req_col_index) < 32'(MAX_POINTS));
   assign hi     = (req_row_index > req_col_index) ? req_row_index : req_col_index;
   assign lo     = (req_row_index > req_col_index) ? req_col_index : req_row_index;
   assign prod   = PW'(hi) * PW'(hi - mpde_pkg::INDEX_PORT_W'(1));

   always_comb begin
      keep                  = 1'b0;
      stage_cmd_in          = stage_cmd_ff;
      stage_cmd_in.op       = mpde_pkg::OP_LOAD;
      stage_cmd_in.addr     = mpde_pkg::MAX_ADDR_W'((prod >> 1) + PW'(lo));
      stage_cmd_in.distance = mpde_pkg::MAX_DIST_W'(DIST_WIDTH'(req_distance_value));
      stage_cmd_in.point    = mpde_pkg::MAX_IDX_W'(req_row_index);
      stage_cmd_in.on       = req_mask_on;
      unique case (req_command)
         mpde_pkg::OP_LOAD: begin
            keep = row_ok && col_ok && (req_row_index != req_col_index);
         end
         mpde_pkg::OP_MASK: begin
            stage_cmd_in.op = mpde_pkg::OP_MASK;
            keep            = row_ok;
         end
         mpde_pkg::OP_EVAL: begin
            stage_cmd_in.op = mpde_pkg::OP_EVAL;
            keep            = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
      stage_valid_in = (stage_valid_ff && cq_full) || (accept && keep);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_cmd_ff <= stage_cmd_in;
      end
   end

endmodule

FILE: src/mpde_back.sv
// Command back end: distance memory, point mask and the evaluate scan.
// Depends on mpde_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "masked_pair_distance_extremes_macros.svh"

module mpde_back #(
   parameter int MAX_POINTS = mpde_pkg::MAX_POINTS_DEFAULT,
   parameter int DIST_WIDTH = mpde_pkg::DIST_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [mpde_pkg::COUNT_PORT_W-1:0]   point_count,
   input  logic                                cq_empty,
   output logic                                cq_pop,
   input  mpde_pkg::cmd_type                   cq_data,
   input  logic                                rq_full,
   output logic                                rq_push,
   output mpde_pkg::res_type                   rq_data
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int TD = MAX_POINTS * (MAX_POINTS - 1) / 2;
   localparam int AW = (TD > 1) ? $clog2(TD) : 1;

   mpde_pkg::state_type    state_ff, state_in;

   logic [DIST_WIDTH-1:0]  dist_mem [TD];
   logic [DIST_WIDTH-1:0]  rd_data_ff;

   logic [MAX_POINTS-1:0]  mask_ff, mask_in;
   logic [CW-1:0]          active_ff, active_in;
   logic [CW-1:0]          n;

   logic [CW-1:0]          i_ff, i_in;
   logic [IW-1:0]          j_ff, j_in;
   logic [AW-1:0]          base_ff, base_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic                   iss_valid, iss_active, iss_last;
   logic [AW-1:0]          iss_addr;

   logic                   s1_valid_ff, s1_active_ff, s1_last_ff;
   logic [IW-1:0]          s1_i_ff, s1_j_ff;

   logic                   dfound_ff, dfound_in;
   logic [DIST_WIDTH-1:0]  dval_ff, dval_in;
   logic [IW-1:0]          d1_ff, d1_in, d2_ff, d2_in;

   logic                   rfound_ff, rfound_in, rf_n;
   logic [DIST_WIDTH-1:0]  rmin_ff, rmin_in, rm_n;
   logic [IW-1:0]          rj_ff, rj_in, rj_n;

   logic                   rowres_valid_ff, rowres_valid_in;
   logic                   rowres_found_ff, rowres_found_in;
   logic [DIST_WIDTH-1:0]  rowres_min_ff, rowres_min_in;
   logic [IW-1:0]          rowres_i_ff, rowres_i_in, rowres_j_ff, rowres_j_in;

   logic                   efound_ff, efound_in;
   logic [DIST_WIDTH-1:0]  eval_ff, eval_in;
   logic [IW-1:0]          e1_ff, e1_in, e2_ff, e2_in;

   logic [IW-1:0]          pt;
   logic [IW-1:0]          row;

   assign n       = (32'(point_count) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(point_count);
   assign pt      = cq_data.point[IW-1:0];
   assign row     = i_ff[IW-1:0];
   assign wr_addr = cq_data.addr[AW-1:0];

   always_comb begin
      rq_data.delta_found    = dfound_ff;
      rq_data.delta_value    = mpde_pkg::DIST_PORT_W'(dval_ff);
      rq_data.delta_first    = mpde_pkg::INDEX_PORT_W'(d1_ff);
      rq_data.delta_second   = mpde_pkg::INDEX_PORT_W'(d2_ff);
      rq_data.epsilon_found  = efound_ff;
      rq_data.epsilon_value  = mpde_pkg::DIST_PORT_W'(eval_ff);
      rq_data.epsilon_first  = mpde_pkg::INDEX_PORT_W'(e1_ff);
      rq_data.epsilon_second = mpde_pkg::INDEX_PORT_W'(e2_ff);
      rq_data.active_count   = mpde_pkg::COUNT_PORT_W'(active_ff);
   end

   always_comb begin
      state_in   = state_ff;
      mask_in    = mask_ff;
      active_in  = active_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      base_in    = base_ff;
      cq_pop     = 1'b0;
      rq_push    = 1'b0;
      wr_en      = 1'b0;
      iss_valid  = 1'b0;
      iss_active = 1'b0;
      iss_last   = 1'b0;
      iss_addr   = base_ff + AW'(j_ff);
      dfound_in  = dfound_ff;
      dval_in    = dval_ff;
      d1_in      = d1_ff;
      d2_in      = d2_ff;
      rfound_in  = rfound_ff;
      rmin_in    = rmin_ff;
      rj_in      = rj_ff;
      efound_in  = efound_ff;
      eval_in    = eval_ff;
      e1_in      = e1_ff;
      e2_in      = e2_ff;

      unique case (state_ff)
         mpde_pkg::ST_IDLE: begin
            if (!cq_empty) begin
               cq_pop = 1'b1;
               unique case (cq_data.op)
                  mpde_pkg::OP_LOAD: begin
                     wr_en = 1'b1;
                  end
                  mpde_pkg::OP_MASK: begin
                     if (mask_ff[pt] != cq_data.on) begin
                        mask_in[pt] = cq_data.on;
                        active_in   = cq_data.on ? active_ff + CW'(1) : active_ff - CW'(1);
                     end
                  end
                  mpde_pkg::OP_EVAL: begin
                     state_in  = mpde_pkg::ST_SCAN;
                     i_in      = '0;
                     j_in      = '0;
                     base_in   = '0;
                     dfound_in = 1'b0;
                     dval_in   = '0;
                     d1_in     = '0;
                     d2_in     = '0;
                     rfound_in = 1'b0;
                     efound_in = 1'b0;
                     eval_in   = '0;
                     e1_in     = '0;
                     e2_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mpde_pkg::ST_SCAN: begin
            if (i_ff >= n) begin
               state_in = mpde_pkg::ST_DRAIN;
            end else if ((i_ff == '0) || !mask_ff[row]) begin
               i_in    = i_ff + CW'(1);
               base_in = base_ff + AW'(i_ff);
               j_in    = '0;
            end else begin
               iss_valid  = 1'b1;
               iss_active = mask_ff[j_ff];
               iss_last   = (j_ff == IW'(i_ff - CW'(1)));
               if (iss_last) begin
                  i_in    = i_ff + CW'(1);
                  base_in = base_ff + AW'(i_ff);
                  j_in    = '0;
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end
         end
         mpde_pkg::ST_DRAIN: begin
            if (!s1_valid_ff && !rowres_valid_ff) begin
               state_in = mpde_pkg::ST_REPLY;
            end
         end
         mpde_pkg::ST_REPLY: begin
            if (!rq_full) begin
               rq_push  = 1'b1;
               state_in = mpde_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mpde_pkg::ST_IDLE;
         end
      endcase

      // compare stage: delta and running row minimum
      rf_n = rfound_ff;
      rm_n = rmin_ff;
      rj_n = rj_ff;
      if (s1_valid_ff && s1_active_ff) begin
         if (!dfound_ff || (rd_data_ff < dval_ff)) begin
            dfound_in = 1'b1;
            dval_in   = rd_data_ff;
            d1_in     = s1_i_ff;
            d2_in     = s1_j_ff;
         end
         if (!rfound_ff || (rd_data_ff < rmin_ff)) begin
            rf_n = 1'b1;
            rm_n = rd_data_ff;
            rj_n = s1_j_ff;
         end
      end
      if (s1_valid_ff) begin
         rfound_in = s1_last_ff ? 1'b0 : rf_n;
         rmin_in   = rm_n;
         rj_in     = rj_n;
      end
      rowres_valid_in = s1_valid_ff && s1_last_ff;
      rowres_found_in = rf_n;
      rowres_min_in   = rm_n;
      rowres_j_in     = rj_n;
      rowres_i_in     = s1_i_ff;

      // row result stage: epsilon
      if (rowres_valid_ff && rowres_found_ff &&
          (!efound_ff || (rowres_min_ff > eval_ff))) begin
         efound_in = 1'b1;
         eval_in   = rowres_min_ff;
         e1_in     = rowres_i_ff;
         e2_in     = rowres_j_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= mpde_pkg::ST_IDLE;
         mask_ff         <= '0;
         active_ff       <= '0;
         s1_valid_ff     <= 1'b0;
         rowres_valid_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mask_ff         <= mask_in;
         active_ff       <= active_in;
         s1_valid_ff     <= iss_valid;
         rowres_valid_ff <= rowres_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff            <= i_in;
      j_ff            <= j_in;
      base_ff         <= base_in;
      s1_active_ff    <= iss_active;
      s1_last_ff      <= iss_last;
      s1_i_ff         <= row;
      s1_j_ff         <= j_ff;
      dfound_ff       <= dfound_in;
      dval_ff         <= dval_in;
      d1_ff           <= d1_in;
      d2_ff           <= d2_in;
      rfound_ff       <= rfound_in;
      rmin_ff         <= rmin_in;
      rj_ff           <= rj_in;
      rowres_found_ff <= rowres_found_in;
      rowres_min_ff   <= rowres_min_in;
      rowres_i_ff     <= rowres_i_in;
      rowres_j_ff     <= rowres_j_in;
      efound_ff       <= efound_in;
      eval_ff         <= eval_in;
      e1_ff           <= e1_in;
      e2_ff           <= e2_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[wr_addr] <= cq_data.distance[DIST_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (iss_valid) begin
         rd_data_ff <= dist_mem[iss_addr];
      end
   end

   `MPDE_ASSERT_IMPLY(a_count_matches_mask, clock, reset, 1'b1,
                      $countones(mask_ff) == 32'(active_ff))
   `MPDE_ASSERT_IMPLY(a_issue_in_range, clock, reset, iss_valid,
                      (state_ff == mpde_pkg::ST_SCAN) && (i_ff < n) && (j_ff < row))
   `MPDE_ASSERT_NEXT(a_row_end_reported, clock, reset, s1_valid_ff && s1_last_ff,
                     rowres_valid_ff)
   `MPDE_ASSERT_NEXT(a_drain_to_reply, clock, reset,
                     (state_ff == mpde_pkg::ST_DRAIN) && !s1_valid_ff && !rowres_valid_ff,
                     state_ff == mpde_pkg::ST_REPLY)

endmodule

FILE: src/masked_pair_distance_extremes.sv
// Loads, mask updates and evaluates pass through a front register and a four-entry command
// queue; the idle back end then carries out a load or mask request as it pops it, so they
// stream at one per cycle while no evaluate is in progress. An evaluate, once popped,
// walks rows 0..n-1 (n = min(point_count, MAX_POINTS)) through the single read port of the
// distance memory: one read for each pair (i, j<i) of an active row, none for row 0 or for
// an inactive row; it then closes the scan, drains the compare stages and posts the result,
// which waits in a two-entry result queue. Distance entries are undefined until loaded;
// there is no clearing pass, so the table is usable straight after reset.
`timescale 1ns / 1ps

module masked_pair_distance_extremes #(
   parameter int MAX_POINTS = mpde_pkg::MAX_POINTS_DEFAULT,
   parameter int DIST_WIDTH = mpde_pkg::DIST_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [1:0]                          req_command,
   input  logic [mpde_pkg::INDEX_PORT_W-1:0]   req_row_index,
   input  logic [mpde_pkg::INDEX_PORT_W-1:0]   req_col_index,
   input  logic [mpde_pkg::DIST_PORT_W-1:0]    req_distance_value,
   input  logic                                req_mask_on,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic                                rsp_delta_found,
   output logic [mpde_pkg::DIST_PORT_W-1:0]    rsp_delta_value,
   output logic [mpde_pkg::INDEX_PORT_W-1:0]   rsp_delta_first,
   output logic [mpde_pkg::INDEX_PORT_W-1:0]   rsp_delta_second,
   output logic                                rsp_epsilon_found,
   output logic [mpde_pkg::DIST_PORT_W-1:0]    rsp_epsilon_value,
   output logic [mpde_pkg::INDEX_PORT_W-1:0]   rsp_epsilon_first,
   output logic [mpde_pkg::INDEX_PORT_W-1:0]   rsp_epsilon_second,
   output logic [mpde_pkg::COUNT_PORT_W-1:0]   rsp_active_count,
   input  logic                                csr_wr_en,
   input  logic [mpde_pkg::COUNT_PORT_W-1:0]   csr_wr_data
);

   logic [mpde_pkg::COUNT_PORT_W-1:0] point_count_ff;

   logic                  cq_push, cq_full, cq_pop, cq_empty;
   mpde_pkg::cmd_type     cq_wdata, cq_rdata;
   logic                  rq_push, rq_full;
   mpde_pkg::res_type     rq_wdata, rq_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= mpde_pkg::POINT_COUNT_RESET;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   mpde_front #(
      .MAX_POINTS (MAX_POINTS),
      .DIST_WIDTH (DIST_WIDTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .req_distance_value (req_distance_value),
      .req_mask_on        (req_mask_on),
      .cq_push            (cq_push),
      .cq_full            (cq_full),
      .cq_data            (cq_wdata)
   );

   mpde_queue #(
      .WIDTH ($bits(mpde_pkg::cmd_type)),
      .DEPTH (mpde_pkg::CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock (clock),
      .reset (reset),
      .push  (cq_push),
      .full  (cq_full),
      .wdata (cq_wdata),
      .pop   (cq_pop),
      .empty (cq_empty),
      .rdata (cq_rdata)
   );

   mpde_back #(
      .MAX_POINTS (MAX_POINTS),
      .DIST_WIDTH (DIST_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .point_count (point_count_ff),
      .cq_empty    (cq_empty),
      .cq_pop      (cq_pop),
      .cq_data     (cq_rdata),
      .rq_full     (rq_full),
      .rq_push     (rq_push),
      .rq_data     (rq_wdata)
   );

   mpde_queue #(
      .WIDTH ($bits(mpde_pkg::res_type)),
      .DEPTH (mpde_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .full  (rq_full),
      .wdata (rq_wdata),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rq_rdata)
   );

   assign rsp_delta_found    = rq_rdata.delta_found;
   assign rsp_delta_value    = rq_rdata.delta_value;
   assign rsp_delta_first    = rq_rdata.delta_first;
   assign rsp_delta_second   = rq_rdata.delta_second;
   assign rsp_epsilon_found  = rq_rdata.epsilon_found;
   assign rsp_epsilon_value  = rq_rdata.epsilon_value;
   assign rsp_epsilon_first  = rq_rdata.epsilon_first;
   assign rsp_epsilon_second = rq_rdata.epsilon_second;
   assign rsp_active_count   = rq_rdata.active_count;

endmodule

FILE: tb/masked_pair_distance_extremes_tb.sv
// Self-checking testbench for masked_pair_distance_extremes: directed and random load, mask
// and evaluate requests, with a scoreboard that recomputes delta and epsilon per evaluate.
// Depends on mpde_pkg and the block's RTL only.
`timescale 1ns / 1ps

module masked_pair_distance_extremes_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int POINTS = 64;
   localparam int SETTLE_CYCLES = 32;
   localparam int IDLE_LIMIT = 20000;
   localparam int LONG_HOLD = 400;
   localparam int TARGET_REQUESTS = 450;
   localparam int PHASE_REQUESTS = 45;

   typedef struct packed {
      logic [1:0]                        command;
      logic [mpde_pkg::INDEX_PORT_W-1:0] row;
      logic [mpde_pkg::INDEX_PORT_W-1:0] col;
      logic [mpde_pkg::DIST_PORT_W-1:0]  distance;
      logic                              on;
   } request_type;

   class distance_extremes_scoreboard;
      logic [mpde_pkg::DIST_PORT_W-1:0] pair_dist [POINTS][POINTS];
      bit                               point_on [POINTS];
      int unsigned                      active_points;
      int unsigned                      point_count;
      mpde_pkg::res_type                pending_answers[$];
      int                               mismatches;
      int                               answers_checked;

      function new();
         foreach (point_on[k]) point_on[k] = 1'b0;
         active_points = 0;
         point_count = mpde_pkg::POINT_COUNT_RESET;
         mismatches = 0;
         answers_checked = 0;
      endfunction

      function mpde_pkg::res_type scan_extremes();
         mpde_pkg::res_type                a;
         int                               n;
         bit                               row_found;
         logic [mpde_pkg::DIST_PORT_W-1:0] row_min;
         logic [mpde_pkg::DIST_PORT_W-1:0] d;
         int                               row_col;
         a = '0;
         n = (point_count > POINTS) ? POINTS : point_count;
         for (int i = 0; i < n; i++) begin
            if (point_on[i]) begin
               row_found = 1'b0;
               row_min = '0;
               row_col = 0;
               for (int j = 0; j < i; j++) begin
                  if (point_on[j]) begin
                     d = pair_dist[i][j];
                     if (!a.delta_found || d < a.delta_value) begin
                        a.delta_found = 1'b1;
                        a.delta_value = d;
                        a.delta_first = mpde_pkg::INDEX_PORT_W'(i);
                        a.delta_second = mpde_pkg::INDEX_PORT_W'(j);
                     end
                     if (!row_found || d < row_min) begin
                        row_found = 1'b1;
                        row_min = d;
                        row_col = j;
                     end
                  end
               end
               if (row_found && (!a.epsilon_found || row_min > a.epsilon_value)) begin
                  a.epsilon_found = 1'b1;
                  a.epsilon_value = row_min;
                  a.epsilon_first = mpde_pkg::INDEX_PORT_W'(i);
                  a.epsilon_second = mpde_pkg::INDEX_PORT_W'(row_col);
               end
            end
         end
         a.active_count = mpde_pkg::COUNT_PORT_W'(active_points);
         return a;
      endfunction

      function void note_request(request_type r);
         if (r.command == mpde_pkg::OP_LOAD) begin
            if (r.row > r.col) begin
               pair_dist[r.row][r.col] = r.distance;
            end else if (r.row < r.col) begin
               pair_dist[r.col][r.row] = r.distance;
            end
         end else if (r.command == mpde_pkg::OP_MASK) begin
            if (point_on[r.row] != r.on) begin
               point_on[r.row] = r.on;
               if (r.on) active_points++;
               else active_points--;
            end
         end else if (r.command == mpde_pkg::OP_EVAL) begin
            pending_answers.push_back(scan_extremes());
         end
      endfunction

      task report_mismatch(string what);
         if (mismatches < 40) $display("ERROR: %s", what);
         mismatches++;
      endtask

      task compare_field(string name, logic [mpde_pkg::DIST_PORT_W-1:0] got,
                         logic [mpde_pkg::DIST_PORT_W-1:0] want);
         if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      answers_checked, name, got, want));
         end
      endtask

      task check_answer(mpde_pkg::res_type got);
         mpde_pkg::res_type want;
         if (pending_answers.size() == 0) begin
            report_mismatch("result popped with no evaluate outstanding");
         end else begin
            want = pending_answers.pop_front();
            compare_field("delta_found", got.delta_found, want.delta_found);
            compare_field("delta_value", got.delta_value, want.delta_value);
            compare_field("delta_first", got.delta_first, want.delta_first);
            compare_field("delta_second", got.delta_second, want.delta_second);
            compare_field("epsilon_found", got.epsilon_found, want.epsilon_found);
            compare_field("epsilon_value", got.epsilon_value, want.epsilon_value);
            compare_field("epsilon_first", got.epsilon_first, want.epsilon_first);
            compare_field("epsilon_second", got.epsilon_second, want.epsilon_second);
            compare_field("active_count", got.active_count, want.active_count);
            answers_checked++;
         end
      endtask
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_push;
   logic                              req_full;
   logic [1:0]                        req_command;
   logic [mpde_pkg::INDEX_PORT_W-1:0] req_row_index;
   logic [mpde_pkg::INDEX_PORT_W-1:0] req_col_index;
   logic [mpde_pkg::DIST_PORT_W-1:0]  req_distance_value;
   logic                              req_mask_on;
   logic                              rsp_empty;
   logic                              rsp_pop;
   logic                              rsp_delta_found;
   logic [mpde_pkg::DIST_PORT_W-1:0]  rsp_delta_value;
   logic [mpde_pkg::INDEX_PORT_W-1:0] rsp_delta_first;
   logic [mpde_pkg::INDEX_PORT_W-1:0] rsp_delta_second;
   logic                              rsp_epsilon_found;
   logic [mpde_pkg::DIST_PORT_W-1:0]  rsp_epsilon_value;
   logic [mpde_pkg::INDEX_PORT_W-1:0] rsp_epsilon_first;
   logic [mpde_pkg::INDEX_PORT_W-1:0] rsp_epsilon_second;
   logic [mpde_pkg::COUNT_PORT_W-1:0] rsp_active_count;
   logic                              csr_wr_en;
   logic [mpde_pkg::COUNT_PORT_W-1:0] csr_wr_data;

   distance_extremes_scoreboard sb;
   bit pair_loaded [POINTS][POINTS];
   int requests_sent = 0;
   int max_active_seen = 0;
   int send_burst_left = 0;
   int rsp_burst_left = 0;
   int idle_cycles = 0;
   bit send_no_gaps = 1'b0;
   bit rsp_hold_pending = 1'b0;

   masked_pair_distance_extremes dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_command        (req_command),
      .req_row_index      (req_row_index),
      .req_col_index      (req_col_index),
      .req_distance_value (req_distance_value),
      .req_mask_on        (req_mask_on),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_delta_found    (rsp_delta_found),
      .rsp_delta_value    (rsp_delta_value),
      .rsp_delta_first    (rsp_delta_first),
      .rsp_delta_second   (rsp_delta_second),
      .rsp_epsilon_found  (rsp_epsilon_found),
      .rsp_epsilon_value  (rsp_epsilon_value),
      .rsp_epsilon_first  (rsp_epsilon_first),
      .rsp_epsilon_second (rsp_epsilon_second),
      .rsp_active_count   (rsp_active_count),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: %0d cycles with no request or result moving", IDLE_LIMIT);
         $display("masked_pair_distance_extremes_tb failed");
         $finish;
      end
   end

   function automatic int draw_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) burst_left = 16;
      return $urandom_range(0, 10);
   endfunction

   function automatic logic [mpde_pkg::DIST_PORT_W-1:0] pick_distance();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2, 3, 4: return 32'h0001_0000 << $urandom_range(0, 2);
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type random_request(logic [1:0] command);
      request_type r;
      r.command = command;
      r.row = mpde_pkg::INDEX_PORT_W'($urandom);
      r.col = mpde_pkg::INDEX_PORT_W'($urandom);
      r.distance = $urandom;
      r.on = 1'($urandom);
      return r;
   endfunction

   task automatic send_request(request_type r);
      int gap;
      gap = send_no_gaps ? 0 : draw_gap(send_burst_left);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command <= r.command;
      req_row_index <= r.row;
      req_col_index <= r.col;
      req_distance_value <= r.distance;
      req_mask_on <= r.on;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(r);
      if (r.command == mpde_pkg::OP_LOAD && r.row != r.col) begin
         pair_loaded[r.row][r.col] = 1'b1;
         pair_loaded[r.col][r.row] = 1'b1;
      end
      requests_sent++;
      if (sb.active_points > max_active_seen) max_active_seen = sb.active_points;
      @(negedge clock);
   endtask

   task automatic send_load(int a, int b, logic [mpde_pkg::DIST_PORT_W-1:0] d);
      request_type r;
      r = random_request(mpde_pkg::OP_LOAD);
      r.row = mpde_pkg::INDEX_PORT_W'(a);
      r.col = mpde_pkg::INDEX_PORT_W'(b);
      r.distance = d;
      send_request(r);
   endtask

   task automatic send_mask(int p, bit on);
      request_type r;
      r = random_request(mpde_pkg::OP_MASK);
      r.row = mpde_pkg::INDEX_PORT_W'(p);
      r.on = on;
      send_request(r);
   endtask

   task automatic send_eval();
      send_request(random_request(mpde_pkg::OP_EVAL));
   endtask

   // load every missing pair with the active points first, so no scan meets an empty entry
   task automatic enable_point(int p);
      for (int q = 0; q < POINTS; q++) begin
         if (q != p && sb.point_on[q] && !pair_loaded[p][q]) begin
            if ($urandom_range(0, 1)) send_load(p, q, pick_distance());
            else send_load(q, p, pick_distance());
         end
      end
      send_mask(p, 1'b1);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (sb.pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_point_count(logic [mpde_pkg::COUNT_PORT_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.point_count = v;
      @(negedge clock);
   endtask

   task automatic random_step(int pool_lo, int pool_span);
      int pick;
      int p;
      int q;
      pick = $urandom_range(0, 99);
      p = pool_lo + $urandom_range(0, pool_span - 1);
      q = $urandom_range(0, 1) ? pool_lo + $urandom_range(0, pool_span - 1)
                               : $urandom_range(0, POINTS - 1);
      if (pick < 18) begin
         send_load(p, q, pick_distance());
      end else if (pick < 42) begin
         enable_point(p);
      end else if (pick < 54) begin
         send_mask(p, 1'b0);
      end else if (pick < 84) begin
         send_eval();
      end else if (pick < 90) begin
         send_request(random_request(OP_UNUSED));
      end else if (pick < 95) begin
         send_load(p, p, pick_distance());
      end else begin
         send_mask(p, sb.point_on[p]);
      end
   endtask

   function automatic logic [mpde_pkg::COUNT_PORT_W-1:0] phase_point_count(int phase);
      case (phase)
         0: return 7'd64;
         1: return 7'd127;
         2: return 7'd2;
         3: return 7'd37;
         4: return 7'd0;
         5: return 7'd64;
         6: return 7'd1;
         7: return 7'd100;
         8: return 7'd50;
         default: return mpde_pkg::COUNT_PORT_W'($urandom_range(3, POINTS));
      endcase
   endfunction

   task automatic run_directed();
      send_eval();
      send_mask(0, 1'b1);
      send_mask(0, 1'b1);
      send_eval();
      send_load(0, 63, 32'hFFFF_FFFF);
      send_mask(63, 1'b1);
      send_eval();
      send_load(5, 5, 32'h0000_0007);
      send_load(5, 0, 32'h0001_0000);
      send_load(63, 5, 32'h0001_0000);
      send_mask(5, 1'b1);
      send_eval();
      send_load(10, 0, 32'h0000_0000);
      send_load(5, 10, 32'h0000_0000);
      send_load(63, 10, 32'h0002_0000);
      send_mask(10, 1'b1);
      send_eval();
      send_request(random_request(OP_UNUSED));
      send_mask(0, 1'b0);
      send_mask(0, 1'b0);
      send_load(63, 5, 32'h0000_0000);
      send_eval();
      wait_drained();
      set_point_count(7'd0);
      send_eval();
      wait_drained();
      set_point_count(7'd11);
      send_eval();
      wait_drained();
      set_point_count(7'd127);
      send_eval();
   endtask

   initial begin : result_drain
      int                gap;
      mpde_pkg::res_type got;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            gap = LONG_HOLD;
         end else begin
            gap = draw_gap(rsp_burst_left);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         got.delta_found = rsp_delta_found;
         got.delta_value = rsp_delta_value;
         got.delta_first = rsp_delta_first;
         got.delta_second = rsp_delta_second;
         got.epsilon_found = rsp_epsilon_found;
         got.epsilon_value = rsp_epsilon_value;
         got.epsilon_first = rsp_epsilon_first;
         got.epsilon_second = rsp_epsilon_second;
         got.active_count = rsp_active_count;
         sb.check_answer(got);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int phase;
      int lo;
      int span;
      int target;
      sb = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_command = mpde_pkg::OP_LOAD;
      req_row_index = '0;
      req_col_index = '0;
      req_distance_value = '0;
      req_mask_on = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      phase = 0;
      while (requests_sent < TARGET_REQUESTS) begin
         wait_drained();
         set_point_count(phase_point_count(phase));
         case (phase % 4)
            0: begin
               lo = 0;
               span = 14;
            end
            1: begin
               lo = 50;
               span = 14;
            end
            2: begin
               lo = $urandom_range(0, 44);
               span = 20;
            end
            default: begin
               lo = 0;
               span = POINTS;
            end
         endcase
         // hold results back while requests keep coming, to fill the block
         if (phase == 2) begin
            rsp_hold_pending = 1'b1;
            send_no_gaps = 1'b1;
            for (int k = 0; k < 24; k++) begin
               if (k % 2 == 0) send_eval();
               else random_step(lo, span);
            end
            send_no_gaps = 1'b0;
         end
         target = requests_sent + PHASE_REQUESTS;
         while (requests_sent < target) random_step(lo, span);
         phase++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Run covered %0d requests and %0d evaluate results, up to %0d points active.",
               requests_sent, sb.answers_checked, max_active_seen);
      $display("point_count took %0d settings, among them 0, 1, 2, 11, 37, 64 and 127.",
               phase + 3);
      if (sb.mismatches == 0) begin
         $display("masked_pair_distance_extremes_tb passed");
      end else begin
         $display("masked_pair_distance_extremes_tb failed");
      end
      $finish;
   end

endmodule
